// File: hdl/slc_pkg.sv
// Shared types, codes and constants of the stroke line canvas.
`default_nettype none

package slc_pkg;

    localparam int unsigned COORD_W = 12;
    localparam int unsigned ERR_W   = 15;

    localparam logic [15:0] GREY_565 = 16'h7BEF;

    localparam logic [1:0] OP_PRESS   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_READ    = 2'd3;

    // Register index as seen on bit 2 of the byte address.
    localparam logic REG_DRAW_COLOR = 1'b0;

    typedef struct packed {
        logic [1:0]                 opcode;
        logic signed [COORD_W-1:0]  x_coord;
        logic signed [COORD_W-1:0]  y_coord;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pixel_raw;
        logic [7:0]  red_8;
        logic [7:0]  green_8;
        logic [7:0]  blue_8;
        logic        in_range;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LINE,
        ST_SWEEP,
        ST_READ,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic sweep;
        logic rd_en;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic line_done;
        logic sweep_done;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: hdl/stroke_line_canvas.sv
// Top level of the stroke line canvas: configuration register and block wiring.
//
// Requests are taken one at a time while o_stall is low. A press walks a Bresenham
// line one pixel per cycle through the single write port of the pixel memory; the
// line runs from the stored last point (or is the new point alone). A read goes
// through a registered memory read. A clear rewrites every memory word in grey,
// one word a cycle. After reset the same clearing pass runs with o_stall high
// before the first request is taken; configuration writes are taken throughout.
`default_nettype none

module stroke_line_canvas
    import slc_pkg::*;
#(
    parameter int unsigned CANVAS_WIDTH  = 256,
    parameter int unsigned CANVAS_HEIGHT = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_in_item    i_item,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_out_item        o_item,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [15:0] r_draw_color;
    t_dp_cmd     w_cmd;
    t_dp_stat    w_stat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw_color <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_DRAW_COLOR) begin
            r_draw_color <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_DRAW_COLOR) ? {16'h0000, r_draw_color} : '0;

    slc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_item.opcode),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_stall  (o_stall)
    );

    slc_datapath #(
        .CANVAS_WIDTH  (CANVAS_WIDTH),
        .CANVAS_HEIGHT (CANVAS_HEIGHT)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_item       (i_item),
        .i_draw_color (r_draw_color),
        .i_stall      (i_stall),
        .o_stat       (w_stat),
        .o_valid      (o_valid),
        .o_item       (o_item)
    );

endmodule

`default_nettype wire

// File: hdl/slc_ctrl.sv
// Controller state machine that sequences requests through the canvas datapath.
`default_nettype none

module slc_ctrl
    import slc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire logic [1:0] i_opcode,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_INIT: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_opcode)
                        OP_PRESS:   n_state = ST_LINE;
                        OP_RELEASE: n_state = ST_RESULT;
                        OP_CLEAR:   n_state = ST_SWEEP;
                        OP_READ:    n_state = ST_READ;
                        default:    n_state = ST_RESULT;
                    endcase
                end
            end
            ST_LINE: begin
                o_cmd.step = 1'b1;
                if (i_stat.line_done) begin
                    n_state = ST_RESULT;
                end
            end
            ST_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_done) begin
                    n_state = ST_RESULT;
                end
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // A new request is only taken while nothing else is in flight.
    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state != ST_IDLE))
        else $error("request taken but controller stayed idle");

    a_emit_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_state == ST_IDLE))
        else $error("result emitted without returning to idle");

    a_no_emit_and_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.emit && o_cmd.load))
        else $error("result and new request in the same cycle");

endmodule

`default_nettype wire

// File: hdl/slc_datapath.sv
// Canvas datapath: pixel memory, line walker, clearing sweep and result register.
`default_nettype none

module slc_datapath
    import slc_pkg::*;
#(
    parameter int unsigned CANVAS_WIDTH  = 256,
    parameter int unsigned CANVAS_HEIGHT = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    input  wire t_in_item    i_item,
    input  wire logic [15:0] i_draw_color,
    input  wire logic        i_stall,
    output t_dp_stat         o_stat,
    output logic             o_valid,
    output t_out_item        o_item
);

    localparam int unsigned XW    = $clog2(CANVAS_WIDTH);
    localparam int unsigned YW    = $clog2(CANVAS_HEIGHT);
    localparam int unsigned AW    = XW + YW;
    localparam int unsigned DEPTH = 1 << AW;

    function automatic logic f_in_canvas(logic signed [COORD_W-1:0] x,
                                         logic signed [COORD_W-1:0] y);
        logic ok_x;
        logic ok_y;
        ok_x = !x[COORD_W-1] && ({1'b0, x} < (COORD_W+1)'(CANVAS_WIDTH));
        ok_y = !y[COORD_W-1] && ({1'b0, y} < (COORD_W+1)'(CANVAS_HEIGHT));
        return ok_x && ok_y;
    endfunction

    function automatic logic [AW-1:0] f_addr(logic signed [COORD_W-1:0] x,
                                             logic signed [COORD_W-1:0] y);
        return {y[YW-1:0], x[XW-1:0]};
    endfunction

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rd_data;

    logic signed [COORD_W-1:0] r_last_x;
    logic signed [COORD_W-1:0] r_last_y;
    logic signed [COORD_W-1:0] r_cx;
    logic signed [COORD_W-1:0] r_cy;
    logic signed [COORD_W-1:0] r_tx;
    logic signed [COORD_W-1:0] r_ty;
    logic signed [COORD_W:0]   r_dx;
    logic signed [COORD_W:0]   r_dy;
    logic                      r_sx_neg;
    logic                      r_sy_neg;
    logic signed [ERR_W-1:0]   r_err;
    logic [1:0]                r_op;
    logic [AW-1:0]             r_sweep;
    logic                      r_out_valid;
    t_out_item                 r_out;

    // Set-up of the line from the stored point, or from the new point alone.
    logic signed [COORD_W-1:0] w_start_x;
    logic signed [COORD_W-1:0] w_start_y;
    logic signed [COORD_W:0]   w_diff_x;
    logic signed [COORD_W:0]   w_diff_y;
    logic signed [COORD_W:0]   w_abs_dx;
    logic signed [COORD_W:0]   w_neg_dy;

    assign w_start_x = r_last_x[COORD_W-1] ? i_item.x_coord : r_last_x;
    assign w_start_y = r_last_x[COORD_W-1] ? i_item.y_coord : r_last_y;
    assign w_diff_x  = {i_item.x_coord[COORD_W-1], i_item.x_coord}
                     - {w_start_x[COORD_W-1], w_start_x};
    assign w_diff_y  = {i_item.y_coord[COORD_W-1], i_item.y_coord}
                     - {w_start_y[COORD_W-1], w_start_y};
    assign w_abs_dx  = w_diff_x[COORD_W] ? -w_diff_x : w_diff_x;
    assign w_neg_dy  = w_diff_y[COORD_W] ? w_diff_y : -w_diff_y;

    // One Bresenham step.
    logic signed [ERR_W:0]   w_e2;
    logic signed [ERR_W:0]   w_dx_w;
    logic signed [ERR_W:0]   w_dy_w;
    logic signed [ERR_W-1:0] w_dx_e;
    logic signed [ERR_W-1:0] w_dy_e;
    logic                    w_x_step;
    logic                    w_y_step;
    logic signed [ERR_W-1:0] w_err_next;
    logic                    w_line_done;

    assign w_e2     = {r_err, 1'b0};
    assign w_dx_e   = {{(ERR_W-COORD_W-1){r_dx[COORD_W]}}, r_dx};
    assign w_dy_e   = {{(ERR_W-COORD_W-1){r_dy[COORD_W]}}, r_dy};
    assign w_dx_w   = {w_dx_e[ERR_W-1], w_dx_e};
    assign w_dy_w   = {w_dy_e[ERR_W-1], w_dy_e};
    assign w_x_step = (w_e2 >= w_dy_w);
    assign w_y_step = (w_e2 <= w_dx_w);
    assign w_err_next = r_err + (w_x_step ? w_dy_e : '0) + (w_y_step ? w_dx_e : '0);
    assign w_line_done = (r_cx == r_tx) && (r_cy == r_ty);

    // Memory ports.
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [15:0]   w_wdata;

    assign w_we    = i_cmd.sweep || (i_cmd.step && f_in_canvas(r_cx, r_cy));
    assign w_waddr = i_cmd.sweep ? r_sweep : f_addr(r_cx, r_cy);
    assign w_wdata = i_cmd.sweep ? GREY_565 : i_draw_color;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[f_addr(r_tx, r_ty)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x <= '1;
            r_last_y <= '1;
            r_sweep  <= '0;
        end else begin
            if (i_cmd.sweep) begin
                r_sweep <= r_sweep + AW'(1);
            end
            if (i_cmd.load) begin
                if (i_item.opcode == OP_PRESS) begin
                    r_last_x <= i_item.x_coord;
                    r_last_y <= i_item.y_coord;
                end else if (i_item.opcode == OP_RELEASE || i_item.opcode == OP_CLEAR) begin
                    r_last_x <= '1;
                    r_last_y <= '1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_item.opcode;
            r_tx     <= i_item.x_coord;
            r_ty     <= i_item.y_coord;
            r_cx     <= w_start_x;
            r_cy     <= w_start_y;
            r_dx     <= w_abs_dx;
            r_dy     <= w_neg_dy;
            r_sx_neg <= (w_diff_x <= 0);
            r_sy_neg <= (w_diff_y <= 0);
            r_err    <= {{(ERR_W-COORD_W-1){w_abs_dx[COORD_W]}}, w_abs_dx}
                      + {{(ERR_W-COORD_W-1){w_neg_dy[COORD_W]}}, w_neg_dy};
        end else if (i_cmd.step && !w_line_done) begin
            r_err <= w_err_next;
            if (w_x_step) begin
                r_cx <= r_sx_neg ? r_cx - COORD_W'(1) : r_cx + COORD_W'(1);
            end
            if (w_y_step) begin
                r_cy <= r_sy_neg ? r_cy - COORD_W'(1) : r_cy + COORD_W'(1);
            end
        end
    end

    // Result: only a read inside the canvas returns anything but zero.
    t_out_item w_result;
    logic      w_read_ok;
    logic [4:0] w_r5;
    logic [5:0] w_g6;
    logic [4:0] w_b5;

    assign w_read_ok = (r_op == OP_READ) && f_in_canvas(r_tx, r_ty);
    assign w_r5 = r_rd_data[15:11];
    assign w_g6 = r_rd_data[10:5];
    assign w_b5 = r_rd_data[4:0];

    always_comb begin
        w_result = '0;
        if (w_read_ok) begin
            w_result.pixel_raw = r_rd_data;
            w_result.red_8     = {w_r5, w_r5[4:2]};
            w_result.green_8   = {w_g6, w_g6[5:4]};
            w_result.blue_8    = {w_b5, w_b5[4:2]};
            w_result.in_range  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= w_result;
        end
    end

    assign o_stat.line_done  = w_line_done;
    assign o_stat.sweep_done = &r_sweep;
    assign o_stat.out_free   = !r_out_valid || !i_stall;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || !i_stall))
        else $error("result register overwritten while stalled");

    a_sweep_rests_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.sweep |-> (r_sweep == '0))
        else $error("clearing sweep left mid-way");

    a_zero_unless_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.in_range) |-> (r_out.pixel_raw == '0 && r_out.red_8 == '0))
        else $error("non-zero result without an in-range read");

    a_no_step_during_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (!i_cmd.sweep && !i_cmd.rd_en))
        else $error("line walk collides with another memory access");

endmodule

`default_nettype wire
